// ----- hw/rtl/bgs_pkg.sv -----
// ---------------------------------------------------------------------------
// Bilinear grid sampler package
// Shared constants, codes, structs and helper functions of the sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package bgs_pkg;

  // Grid geometry. The grid is split into four banks by row and column parity.
  localparam int GRID_SIZE      = 512;
  localparam int GRID_BITS      = $clog2(GRID_SIZE);
  localparam logic [GRID_BITS-1:0] GRID_LAST = GRID_BITS'(GRID_SIZE - 1);
  localparam int NUM_BANKS      = 4;
  localparam int BANK_SEL_BITS  = 2;
  localparam int BANK_IDX_BITS  = GRID_BITS - 1;
  localparam int BANK_ADDR_BITS = 2 * BANK_IDX_BITS;
  localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

  // Number formats.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int POS_BITS    = 24;
  localparam int POS_FRAC    = 8;
  localparam int SCALE_BITS  = 24;
  localparam int SCALE_FRAC  = 16;
  localparam int PROD_BITS   = POS_BITS + SCALE_BITS;
  localparam int PROD_FRAC   = POS_FRAC + SCALE_FRAC;
  localparam int WHOLE_BITS  = PROD_BITS - PROD_FRAC;

  // Blend arithmetic widths.
  localparam int WEIGHT_BITS = FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam int H_BITS      = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int T_BITS      = H_BITS + WEIGHT_BITS;

  // Configuration port.
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [POS_BITS-1:0]   WORLD_SIZE_RST = POS_BITS'(25600);
  localparam logic [SCALE_BITS-1:0] CELL_SCALE_RST = SCALE_BITS'(335544);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_MAP_READY  = 2'd0,
    CFG_WORLD_SIZE = 2'd1,
    CFG_CELL_SCALE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Result queue.
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  typedef struct packed {
    logic                 en;
    logic [GRID_BITS-1:0] y0;
    logic [GRID_BITS-1:0] y1;
    logic [GRID_BITS-1:0] x0;
    logic [GRID_BITS-1:0] x1;
  } grid_rd_t;

  typedef struct packed {
    logic                   en;
    logic [GRID_BITS-1:0]   row;
    logic [GRID_BITS-1:0]   col;
    logic [SAMPLE_BITS-1:0] data;
  } grid_wr_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] c00;
    logic signed [SAMPLE_BITS-1:0] c01;
    logic signed [SAMPLE_BITS-1:0] c10;
    logic signed [SAMPLE_BITS-1:0] c11;
  } corners_t;

  typedef struct packed {
    logic                 valid;
    logic                 inb;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
  } blend_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          in_bounds;
  } result_t;

  // Clamp a whole cell index to the last row or column.
  function automatic logic [GRID_BITS-1:0] clamp_idx(input logic [WHOLE_BITS:0] v);
    logic [WHOLE_BITS:0] last_ext;
    last_ext = (WHOLE_BITS + 1)'(GRID_LAST);
    return (v > last_ext) ? GRID_LAST : v[GRID_BITS-1:0];
  endfunction

  // Weight of the near cell: one minus the fraction.
  function automatic logic signed [WEIGHT_BITS-1:0] near_weight(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] w;
    w = FRAC_ONE - {1'b0, f};
    return $signed({1'b0, w});
  endfunction

  // Weight of the far cell: the fraction itself.
  function automatic logic signed [WEIGHT_BITS-1:0] far_weight(input logic [FRAC_BITS-1:0] f);
    return $signed({2'b00, f});
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bgs_req_if.sv -----
// ---------------------------------------------------------------------------
// Sampler request channel
// Valid/ready channel carrying one write or sample item.
// ---------------------------------------------------------------------------
`default_nettype none

interface bgs_req_if import bgs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [POS_BITS-1:0]           pos_x;
  logic [POS_BITS-1:0]           pos_y;
  logic [GRID_BITS-1:0]          cell_row;
  logic [GRID_BITS-1:0]          cell_col;
  logic signed [SAMPLE_BITS-1:0] cell_value;

  modport source (
    output valid, command, pos_x, pos_y, cell_row, cell_col, cell_value,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, cell_row, cell_col, cell_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/bgs_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Sampler result channel
// Valid/ready channel carrying one interpolated sample item.
// ---------------------------------------------------------------------------
`default_nettype none

interface bgs_rsp_if import bgs_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          in_bounds;

  modport source (output valid, sample_value, in_bounds, input ready);
  modport sink (input valid, sample_value, in_bounds, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bgs_cfg_if.sv -----
// ---------------------------------------------------------------------------
// Sampler configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface bgs_cfg_if import bgs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bgs_grid_mem.sv -----
// ---------------------------------------------------------------------------
// Four-bank grid store
// Sample grid split by row and column parity so that the four corners of a
// bilinear footprint are read in the same cycle, one entry from each bank.
// ---------------------------------------------------------------------------
`default_nettype none

module bgs_grid_mem import bgs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  grid_rd_t rd,
  input  grid_wr_t wr,
  output corners_t corners
);

  logic [SAMPLE_BITS-1:0] bank_q [NUM_BANKS];
  logic                   y0_par;
  logic                   y1_par;
  logic                   x0_par;
  logic                   x1_par;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic ROW_PAR = 1'((b >> 1) & 1);
    localparam logic COL_PAR = 1'(b & 1);

    logic [SAMPLE_BITS-1:0]    mem [BANK_DEPTH];
    logic [GRID_BITS-1:0]      row_sel;
    logic [GRID_BITS-1:0]      col_sel;
    logic [BANK_ADDR_BITS-1:0] raddr;
    logic [BANK_ADDR_BITS-1:0] waddr;
    logic                      we;

    // Of the two rows (columns) in the footprint, this bank holds the one
    // with its parity. A clamped footprint uses one row twice.
    assign row_sel = (rd.y0[0] == ROW_PAR) ? rd.y0 : rd.y1;
    assign col_sel = (rd.x0[0] == COL_PAR) ? rd.x0 : rd.x1;
    assign raddr   = {row_sel[GRID_BITS-1:1], col_sel[GRID_BITS-1:1]};
    assign waddr   = {wr.row[GRID_BITS-1:1], wr.col[GRID_BITS-1:1]};
    assign we      = wr.en && (wr.row[0] == ROW_PAR) && (wr.col[0] == COL_PAR);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wr.data;
      end
    end

    always_ff @(posedge clk) begin
      if (rd.en) begin
        bank_q[b] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      y0_par <= rd.y0[0];
      y1_par <= rd.y1[0];
      x0_par <= rd.x0[0];
      x1_par <= rd.x1[0];
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick(input logic rp, input logic cp);
    logic [SAMPLE_BITS-1:0] v;
    case ({rp, cp})
      2'b00:   v = bank_q[0];
      2'b01:   v = bank_q[1];
      2'b10:   v = bank_q[2];
      default: v = bank_q[3];
    endcase
    return v;
  endfunction

  always_comb begin
    corners.c00 = $signed(pick(y0_par, x0_par));
    corners.c01 = $signed(pick(y0_par, x1_par));
    corners.c10 = $signed(pick(y1_par, x0_par));
    corners.c11 = $signed(pick(y1_par, x1_par));
  end

  // One item occupies the access stage, so a write and a read never meet.
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(rd.en && wr.en))
    else $error("grid store got a read and a write in one cycle");

  // The neighbor index is the base plus one, or both sit on the last line.
  a_footprint: assert property (@(posedge clk) disable iff (rst)
    rd.en |-> ((rd.x1 == rd.x0 + 1'b1) || (rd.x0 == GRID_LAST && rd.x1 == GRID_LAST)) &&
              ((rd.y1 == rd.y0 + 1'b1) || (rd.y0 == GRID_LAST && rd.y1 == GRID_LAST)))
    else $error("grid footprint is not two adjacent lines");

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_blend.sv -----
// ---------------------------------------------------------------------------
// Bilinear blend
// Two-stage weighted sum: horizontal blend of both rows, then vertical blend
// and truncation toward minus infinity.
// ---------------------------------------------------------------------------
`default_nettype none

module bgs_blend import bgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  blend_ctl_t ctl,
  input  corners_t   corners,
  output logic       push,
  output result_t    push_data
);

  logic signed [WEIGHT_BITS-1:0] wx_near;
  logic signed [WEIGHT_BITS-1:0] wx_far;
  logic signed [H_BITS-1:0]      h0_sum;
  logic signed [H_BITS-1:0]      h1_sum;

  logic                          a_valid;
  logic                          a_inb;
  logic [FRAC_BITS-1:0]          a_fy;
  logic signed [H_BITS-1:0]      a_h0;
  logic signed [H_BITS-1:0]      a_h1;

  logic signed [WEIGHT_BITS-1:0] wy_near;
  logic signed [WEIGHT_BITS-1:0] wy_far;
  logic signed [T_BITS-1:0]      t_sum;

  // Horizontal blend of the upper and lower row. Both factors are widened to
  // the sum width first so that the products cannot wrap.
  always_comb begin
    wx_near = near_weight(ctl.fx);
    wx_far  = far_weight(ctl.fx);
    h0_sum  = H_BITS'($signed(corners.c00)) * H_BITS'(wx_near)
            + H_BITS'($signed(corners.c01)) * H_BITS'(wx_far);
    h1_sum  = H_BITS'($signed(corners.c10)) * H_BITS'(wx_near)
            + H_BITS'($signed(corners.c11)) * H_BITS'(wx_far);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    a_inb <= ctl.inb;
    a_fy  <= ctl.fy;
    a_h0  <= h0_sum;
    a_h1  <= h1_sum;
  end

  // Vertical blend; the integer part of the exact sum is a floor.
  always_comb begin
    wy_near = near_weight(a_fy);
    wy_far  = far_weight(a_fy);
    t_sum   = T_BITS'(a_h0) * T_BITS'(wy_near) + T_BITS'(a_h1) * T_BITS'(wy_far);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    push_data.sample_value <= a_inb ? t_sum[2*FRAC_BITS +: SAMPLE_BITS] : '0;
    push_data.in_bounds    <= a_inb;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bgs_rsp_fifo.sv -----
// ---------------------------------------------------------------------------
// Result queue
// Small queue between the blend pipeline and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module bgs_rsp_fifo import bgs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_data,
  bgs_rsp_if.source        rsp
);

  result_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;
  logic                     pop;

  assign pop              = rsp.valid && rsp.ready;
  assign rsp.valid        = (count != '0);
  assign rsp.sample_value = slots[rd_ptr].sample_value;
  assign rsp.in_bounds    = slots[rd_ptr].in_bounds;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
    end
  end

  // Admission credits upstream keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < FIFO_CNT_BITS'(FIFO_DEPTH)) || pop)
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- hw/rtl/bilinear_grid_sampler.sv -----
// ---------------------------------------------------------------------------
// Bilinear grid sampler
// Square grid of signed samples with a pipelined bilinear lookup.
// ---------------------------------------------------------------------------
// The sampler takes one item per clock cycle, writes and samples mixed in
// any order. A write item stores one cell of the 512 x 512 grid and gives no
// result. A sample item scales its Q16.8 position by cell_scale, reads the
// four cells around it in the same cycle and returns their bilinear blend,
// truncated toward minus infinity. The one-item-per-cycle rate comes from
// the grid store: it is split into four banks by row and column parity, so
// each corner of a footprint lives in a different bank and every bank
// serves one read or one write per cycle. Writes and reads use the same
// pipeline stage, so every sample sees exactly the writes accepted before
// it. Results go through an eight-entry queue; the request channel stays
// ready while fewer than eight sample results are in flight or waiting, so
// a stalled result channel stops intake only once that queue is full. The
// grid has no reset and no clearing pass: a cell reads back garbage until
// it has been written. Configuration writes are always accepted and should
// be issued only while no sample is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module bilinear_grid_sampler import bgs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bgs_req_if.sink   req,
  bgs_rsp_if.source rsp,
  bgs_cfg_if.sink   cfg
);

  // Configuration registers.
  logic                  map_ready;
  logic [POS_BITS-1:0]   world_size;
  logic [SCALE_BITS-1:0] cell_scale;

  // Request stage: the item as accepted, with its bounds check done.
  logic                   s1_valid;
  logic                   s1_sample;
  logic                   s1_inb;
  logic [POS_BITS-1:0]    s1_px;
  logic [POS_BITS-1:0]    s1_py;
  logic [GRID_BITS-1:0]   s1_row;
  logic [GRID_BITS-1:0]   s1_col;
  logic [SAMPLE_BITS-1:0] s1_val;

  // Scale stage: grid-unit positions.
  logic                   s2_valid;
  logic                   s2_sample;
  logic                   s2_inb;
  logic [PROD_BITS-1:0]   s2_prod_x;
  logic [PROD_BITS-1:0]   s2_prod_y;
  logic [GRID_BITS-1:0]   s2_row;
  logic [GRID_BITS-1:0]   s2_col;
  logic [SAMPLE_BITS-1:0] s2_val;

  logic [WHOLE_BITS:0]    whole_x;
  logic [WHOLE_BITS:0]    whole_y;
  grid_rd_t               grid_rd;
  grid_wr_t               grid_wr;
  corners_t               corners;

  // Read-data stage control for the blend.
  blend_ctl_t             s3_ctl;

  logic                   push;
  result_t                push_data;

  // Results that are accepted but not yet delivered.
  logic [FIFO_CNT_BITS-1:0] outstanding;
  logic [FIFO_CNT_BITS-1:0] outstanding_next;
  logic                     req_hs;
  logic                     req_sample;
  logic                     rsp_hs;

  // ------------------------------------------------------------------
  // Configuration writes. Unknown register indexes are dropped.
  // ------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_ready  <= 1'b0;
      world_size <= WORLD_SIZE_RST;
      cell_scale <= CELL_SCALE_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.addr))
        CFG_MAP_READY:  map_ready  <= cfg.data[0];
        CFG_WORLD_SIZE: world_size <= cfg.data[POS_BITS-1:0];
        CFG_CELL_SCALE: cell_scale <= cfg.data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Admission. Each sample takes one slot of the result queue up front,
  // so the pipeline itself never has to stall.
  // ------------------------------------------------------------------
  assign req.ready  = (outstanding < FIFO_CNT_BITS'(FIFO_DEPTH));
  assign req_hs     = req.valid && req.ready;
  assign req_sample = (cmd_t'(req.command) == CMD_SAMPLE);
  assign rsp_hs     = rsp.valid && rsp.ready;

  always_comb begin
    outstanding_next = outstanding + FIFO_CNT_BITS'(req_hs && req_sample)
                     - FIFO_CNT_BITS'(rsp_hs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  // ------------------------------------------------------------------
  // Request stage.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_hs;
    end
  end

  always_ff @(posedge clk) begin
    s1_sample <= req_sample;
    s1_inb    <= map_ready && (req.pos_x < world_size) && (req.pos_y < world_size);
    s1_px     <= req.pos_x;
    s1_py     <= req.pos_y;
    s1_row    <= req.cell_row;
    s1_col    <= req.cell_col;
    s1_val    <= req.cell_value;
  end

  // ------------------------------------------------------------------
  // Scale stage: one 24 x 24 multiplier per axis gives a Q24.24 position.
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_sample <= s1_sample;
    s2_inb    <= s1_inb;
    s2_prod_x <= PROD_BITS'(s1_px) * PROD_BITS'(cell_scale);
    s2_prod_y <= PROD_BITS'(s1_py) * PROD_BITS'(cell_scale);
    s2_row    <= s1_row;
    s2_col    <= s1_col;
    s2_val    <= s1_val;
  end

  // ------------------------------------------------------------------
  // Access stage: clamp the footprint and issue the bank reads, or
  // perform the write. The cell address is exactly as wide as the grid
  // index, so every write lands inside the grid.
  // ------------------------------------------------------------------
  always_comb begin
    whole_x    = {1'b0, s2_prod_x[PROD_BITS-1:PROD_FRAC]};
    whole_y    = {1'b0, s2_prod_y[PROD_BITS-1:PROD_FRAC]};
    grid_rd.en = s2_valid && s2_sample;
    grid_rd.x0 = clamp_idx(whole_x);
    grid_rd.x1 = clamp_idx(whole_x + 1'b1);
    grid_rd.y0 = clamp_idx(whole_y);
    grid_rd.y1 = clamp_idx(whole_y + 1'b1);

    grid_wr.en   = s2_valid && !s2_sample;
    grid_wr.row  = s2_row;
    grid_wr.col  = s2_col;
    grid_wr.data = s2_val;
  end

  bgs_grid_mem u_grid_mem (
    .clk     (clk),
    .rst     (rst),
    .rd      (grid_rd),
    .wr      (grid_wr),
    .corners (corners)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl.valid <= 1'b0;
    end else begin
      s3_ctl.valid <= s2_valid && s2_sample;
    end
    s3_ctl.inb <= s2_inb;
    s3_ctl.fx  <= s2_prod_x[PROD_FRAC-1 -: FRAC_BITS];
    s3_ctl.fy  <= s2_prod_y[PROD_FRAC-1 -: FRAC_BITS];
  end

  // ------------------------------------------------------------------
  // Blend and result queue.
  // ------------------------------------------------------------------
  bgs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .ctl       (s3_ctl),
    .corners   (corners),
    .push      (push),
    .push_data (push_data)
  );

  bgs_rsp_fifo u_rsp_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .rsp       (rsp)
  );

  // The credit count never exceeds the queue it stands for.
  a_credit_range: assert property (@(posedge clk) disable iff (rst)
    outstanding <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("outstanding result count out of range");

  // A sample outside the world or on a map not ready comes back as zero.
  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.in_bounds) |-> (rsp.sample_value == '0))
    else $error("out-of-bounds result is not zero");

endmodule

`default_nettype wire

// ----- tb/bilinear_grid_sampler_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bilinear grid sampler testbench
// Loads grid cells through write items and checks sampled, interpolated
// values and the in-bounds flag against a cycle-free predictor held in a small
// scoreboard class, over several register settings with random idling and a
// long stall of the result channel.
// ---------------------------------------------------------------------------

module bilinear_grid_sampler_tb;
  import bgs_pkg::*;

  localparam int     MAX_REPORTS  = 10;
  localparam int     IDLE_MAX     = 12;
  localparam int     LONG_HOLD    = 300;
  localparam int     DRAIN_CYCLES = 16;
  localparam longint TIMEOUT_NS   = 20_000_000;
  localparam int unsigned POS_TOP = (1 << POS_BITS) - 1;

  // One request item as the sender builds it.
  typedef struct {
    cmd_t                          command;
    logic [POS_BITS-1:0]           pos_x;
    logic [POS_BITS-1:0]           pos_y;
    logic [GRID_BITS-1:0]          row;
    logic [GRID_BITS-1:0]          col;
    logic signed [SAMPLE_BITS-1:0] value;
  } grid_op_t;

  // The scoreboard mirrors the grid contents and the three registers. Every
  // accepted sample item queues the value it must return; every accepted
  // result is compared with the oldest value waiting.
  class sample_scoreboard;
    logic signed [SAMPLE_BITS-1:0] grid [int];
    logic                          map_on;
    logic [POS_BITS-1:0]           world_lim;
    logic [SCALE_BITS-1:0]         scale;
    result_t                       expected_q[$];
    int                            errors;
    int                            checked;

    function void clear();
      grid.delete();
      expected_q.delete();
      errors    = 0;
      checked   = 0;
      map_on    = 1'b0;
      world_lim = WORLD_SIZE_RST;
      scale     = CELL_SCALE_RST;
    endfunction

    function int cell_key(logic [GRID_BITS-1:0] r, logic [GRID_BITS-1:0] c);
      return int'(r) * GRID_SIZE + int'(c);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        CFG_MAP_READY:  map_on = d[0];
        CFG_WORLD_SIZE: world_lim = d[POS_BITS-1:0];
        CFG_CELL_SCALE: scale = d[SCALE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Scale one coordinate into grid units: the whole part gives the base
    // cell and its neighbor, both clamped to the last row or column, and the
    // top fraction bits give the blend weight.
    function void locate(input logic [POS_BITS-1:0] pos,
                         output logic [GRID_BITS-1:0] lo,
                         output logic [GRID_BITS-1:0] hi,
                         output logic [FRAC_BITS-1:0] frac);
      logic [PROD_BITS-1:0]  prod;
      logic [WHOLE_BITS:0]   whole;
      prod  = PROD_BITS'(pos) * PROD_BITS'(scale);
      whole = {1'b0, prod[PROD_BITS-1:PROD_FRAC]};
      frac  = prod[PROD_FRAC-1 -: FRAC_BITS];
      lo    = (whole > (WHOLE_BITS + 1)'(GRID_LAST)) ? GRID_LAST : whole[GRID_BITS-1:0];
      whole = whole + 1'b1;
      hi    = (whole > (WHOLE_BITS + 1)'(GRID_LAST)) ? GRID_LAST : whole[GRID_BITS-1:0];
    endfunction

    function void note_input(grid_op_t op);
      logic [GRID_BITS-1:0] x0, x1, y0, y1;
      logic [FRAC_BITS-1:0] fx, fy;
      longint               c00, c01, c10, c11, fxl, fyl, nx, ny, top_row, bot_row, acc;
      result_t              r;
      if (op.command == CMD_WRITE) begin
        grid[cell_key(op.row, op.col)] = op.value;
      end else if (!map_on || op.pos_x >= world_lim || op.pos_y >= world_lim) begin
        r.sample_value = '0;
        r.in_bounds    = 1'b0;
        expected_q.insert(expected_q.size(), r);
      end else begin
        locate(op.pos_x, x0, x1, fx);
        locate(op.pos_y, y0, y1, fy);
        c00 = grid[cell_key(y0, x0)];
        c01 = grid[cell_key(y0, x1)];
        c10 = grid[cell_key(y1, x0)];
        c11 = grid[cell_key(y1, x1)];
        fxl = fx;
        fyl = fy;
        nx  = (longint'(1) << FRAC_BITS) - fxl;
        ny  = (longint'(1) << FRAC_BITS) - fyl;
        top_row = c00 * nx + c01 * fxl;
        bot_row = c10 * nx + c11 * fxl;
        // The blend is exact; the shift cuts it toward minus infinity.
        acc = (top_row * ny + bot_row * fyl) >>> (2 * FRAC_BITS);
        r.sample_value = acc[SAMPLE_BITS-1:0];
        r.in_bounds    = 1'b1;
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_result(logic signed [SAMPLE_BITS-1:0] v, logic inb);
      result_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: value %0d in_bounds %0b",
                   checked, v, inb);
      end else begin
        exp_r = expected_q.pop_front();
        if (v !== exp_r.sample_value || inb !== exp_r.in_bounds) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result %0d mismatch: sample_value exp %0d got %0d, in_bounds exp %0b got %0b",
                     checked, exp_r.sample_value, v, exp_r.in_bounds, inb);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bgs_req_if req_ch ();
  bgs_rsp_if rsp_ch ();
  bgs_cfg_if cfg_ch ();

  bilinear_grid_sampler dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  sample_scoreboard sb;

  // Sender-side idling is drawn in the main process; the result side reads
  // its own limit and a count of long-stall requests, both set by the main
  // process with nonblocking writes so the two processes never race.
  int req_idle_max;
  int rsp_idle_max = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int rsp_wait     = 0;

  always #10 clk = ~clk;

  // Result side. Each accepted item is checked, then a new wait is drawn.
  // A long stall request drops ready for a fixed stretch regardless, so the
  // result queue fills and the sampler stops taking requests.
  always @(posedge clk) begin : rsp_side
    int g;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_wait     <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result(rsp_ch.sample_value, rsp_ch.in_bounds);
      if (hold_served != hold_reqs) begin
        hold_served  <= hold_reqs;
        rsp_ch.ready <= 1'b0;
        rsp_wait     <= LONG_HOLD;
      end else if (rsp_ch.ready) begin
        if (rsp_ch.valid) begin
          g = $urandom_range(0, rsp_idle_max);
          if (g != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= g - 1;
          end
        end
      end else if (rsp_wait == 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_wait <= rsp_wait - 1;
      end
    end
  end

  // Offer one item after a random gap and hold it until it is taken. Valid
  // stays high into the next item when that one comes without a gap.
  task automatic send_op(grid_op_t op);
    int gap;
    gap = $urandom_range(0, req_idle_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= op.command;
    req_ch.pos_x      <= op.pos_x;
    req_ch.pos_y      <= op.pos_y;
    req_ch.cell_row   <= op.row;
    req_ch.cell_col   <= op.col;
    req_ch.cell_value <= op.value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_input(op);
  endtask

  // Sample values lean toward the two extremes now and then.
  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic write_cell(logic [GRID_BITS-1:0] r, logic [GRID_BITS-1:0] c,
                            logic signed [SAMPLE_BITS-1:0] v);
    grid_op_t op;
    op.command = CMD_WRITE;
    op.pos_x   = POS_BITS'($urandom);
    op.pos_y   = POS_BITS'($urandom);
    op.row     = r;
    op.col     = c;
    op.value   = v;
    send_op(op);
  endtask

  // A cell reads back garbage until written, so every cell a sample may
  // touch gets a write item first if it has none yet.
  task automatic sample_at(logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] py);
    logic [GRID_BITS-1:0] x0, x1, y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;
    grid_op_t             op;
    sb.locate(px, x0, x1, fx);
    sb.locate(py, y0, y1, fy);
    if (!sb.grid.exists(sb.cell_key(y0, x0))) write_cell(y0, x0, rand_sample());
    if (!sb.grid.exists(sb.cell_key(y0, x1))) write_cell(y0, x1, rand_sample());
    if (!sb.grid.exists(sb.cell_key(y1, x0))) write_cell(y1, x0, rand_sample());
    if (!sb.grid.exists(sb.cell_key(y1, x1))) write_cell(y1, x1, rand_sample());
    op.command = CMD_SAMPLE;
    op.pos_x   = px;
    op.pos_y   = py;
    op.row     = GRID_BITS'($urandom);
    op.col     = GRID_BITS'($urandom);
    op.value   = SAMPLE_BITS'($urandom);
    send_op(op);
  endtask

  // Wait until every expected result is back, then let any write item
  // still in the pipeline finish before registers change.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Valid stays high into the next register write; the caller drops it
  // after the last one.
  task automatic set_reg(cfg_reg_t idx, int unsigned d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= CFG_DATA_BITS'(d);
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, CFG_DATA_BITS'(d));
  endtask

  task automatic setup(bit on, int unsigned world, int unsigned scale);
    settle();
    set_reg(CFG_MAP_READY, on);
    set_reg(CFG_WORLD_SIZE, world);
    set_reg(CFG_CELL_SCALE, scale);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly positions inside the world (and below pos_hi, which keeps the
  // footprint small), some past its edge, and a few anywhere.
  function automatic logic [POS_BITS-1:0] pick_pos(int unsigned pos_hi);
    int unsigned lim, roll;
    lim = sb.world_lim - 1;
    if (pos_hi < lim) lim = pos_hi;
    roll = $urandom_range(0, 99);
    if (roll < 85) return POS_BITS'($urandom_range(0, lim));
    if (roll < 95 && sb.world_lim != POS_TOP)
      return POS_BITS'($urandom_range(sb.world_lim, POS_TOP));
    return POS_BITS'($urandom);
  endfunction

  // Random samples, with a stray write item now and then on any cell.
  task automatic run_phase(int n_samples, int unsigned pos_hi, int req_idle, int rsp_idle);
    logic [POS_BITS-1:0] px, py;
    req_idle_max = req_idle;
    rsp_idle_max <= rsp_idle;
    for (int i = 0; i < n_samples; i++) begin
      if ($urandom_range(0, 6) == 0)
        write_cell(GRID_BITS'($urandom), GRID_BITS'($urandom), rand_sample());
      px = pick_pos(pos_hi);
      py = pick_pos(pos_hi);
      sample_at(px, py);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst               = 1'b1;
    req_idle_max      = 0;
    req_ch.valid      = 1'b0;
    req_ch.command    = CMD_WRITE;
    req_ch.pos_x      = '0;
    req_ch.pos_y      = '0;
    req_ch.cell_row   = '0;
    req_ch.cell_col   = '0;
    req_ch.cell_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.addr       = CFG_MAP_READY;
    cfg_ch.data       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Right after reset the map is not ready, so a sample
    // in bounds still returns zero.
    write_cell(0, 0, 16'sh7FFF);
    write_cell(0, 1, 16'sh8000);
    write_cell(1, 0, -16'sd1);
    write_cell(1, 1, 16'sd1);
    sample_at(0, 0);
    settle();
    set_reg(CFG_MAP_READY, 1);
    cfg_ch.valid <= 1'b0;
    // Reset world and scale: 5.12 cells per world unit. A zero fraction
    // returns the base cell; a half fraction blends the extremes and the
    // negative blends exercise truncation toward minus infinity.
    sample_at(0, 0);
    sample_at(25, 0);
    sample_at(0, 25);
    sample_at(25, 25);
    sample_at(1, 1);
    // The last position inside the world clamps both neighbors to the last
    // row and column, so the result is that corner cell exactly.
    write_cell(GRID_LAST, GRID_LAST, 16'sh8000);
    sample_at(25599, 25599);
    sample_at(25599, 0);
    // At or beyond the world size on either axis.
    sample_at(25600, 0);
    sample_at(0, 25600);
    sample_at(POS_TOP, POS_TOP);

    // Small 16 x 16 footprint, idling on both sides.
    setup(1, 16 * 256, 1 << SCALE_FRAC);
    run_phase(100, POS_TOP, IDLE_MAX, IDLE_MAX);

    // Largest world, smallest scale: every position lands in the first cell
    // and only the fraction moves. The sender never idles while the result
    // side holds off for a long stretch, so intake has to stall.
    setup(1, POS_TOP, 1);
    hold_reqs <= hold_reqs + 1;
    run_phase(80, POS_TOP, 0, IDLE_MAX);

    // Largest scale: cell index follows the position, up past the last row.
    setup(1, POS_TOP, POS_TOP);
    run_phase(25, 520, IDLE_MAX, 0);

    // Smallest world: only the origin is inside.
    setup(1, 1, $urandom_range(1, POS_TOP));
    run_phase(20, POS_TOP, 5, 5);

    // Map not ready: everything reads as zero.
    setup(0, $urandom_range(1, POS_TOP), $urandom_range(1, 4 << SCALE_FRAC));
    run_phase(30, POS_TOP, IDLE_MAX, IDLE_MAX);

    // Random small settings, no idling at all.
    setup(1, $urandom_range(256, 8192), $urandom_range(1, 2 << SCALE_FRAC));
    run_phase(100, POS_TOP, 0, 0);

    // Back to the reset setting, spread over the whole grid.
    setup(1, 25600, 335544);
    run_phase(20, POS_TOP, IDLE_MAX, IDLE_MAX);

    settle();
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop in case the sampler hangs on either channel.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
